// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while in reset.
`define AOS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication on the next cycle, held off while in reset.
`define AOS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/aos_pkg.sv =====
`timescale 1ns / 1ps
package aos_pkg;

  localparam int CHANNELS     = 2;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int SAMPLE_W = 16;
  localparam int MUL_A_W  = 44;
  localparam int MUL_B_W  = 16;
  localparam int MUL_P_W  = 60;
  localparam int MUL_C_W  = $clog2(MUL_B_W);
  localparam int ANG_W    = 32;

  typedef enum logic [1:0] {
    REG_DRIVE   = 2'd0,
    REG_INV     = 2'd1,
    REG_WET_MIX = 2'd2,
    REG_VOLUME  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DRIVE,
    S_CORDIC,
    S_MUL_INV,
    S_MUL_DRY,
    S_MUL_WET,
    S_MUL_VOL,
    S_OUT
  } state_e;

  typedef logic [31:0] turn_tab_t [CORDIC_STEPS];

  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // (2/pi)*atan(2^-i) in Q.30, from a truncated series in Q.32
  function automatic turn_tab_t build_turn_tab();
    turn_tab_t       tab;
    longint unsigned rad;
    longint unsigned term;
    int              e;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        tab[i] = 32'h2000_0000;
      end else begin
        rad = 0;
        for (int k = 0; k < 17; k++) begin
          e = i * (2 * k + 1);
          if (e <= 32) begin
            term = udiv64(64'd1 << (32 - e), longint'(2 * k + 1));
            rad  = (k % 2 == 1) ? rad - term : rad + term;
          end
        end
        tab[i] = 32'((rad * 64'hA2F9_836E + (64'd1 << 33)) >> 34);
      end
    end
    return tab;
  endfunction

  localparam turn_tab_t TURN_TAB = build_turn_tab();

endpackage

// ===== hdl/aos_mul.sv =====
`timescale 1ns / 1ps
module aos_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [aos_pkg::MUL_A_W-1:0]   a_i,
  input  logic        [aos_pkg::MUL_B_W-1:0]   b_i,
  output logic                                 done_o,
  output logic signed [aos_pkg::MUL_P_W-1:0]   p_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [aos_pkg::MUL_C_W-1:0]         cnt_q;
  logic signed [aos_pkg::MUL_A_W-1:0]  a_q;
  logic signed [aos_pkg::MUL_A_W:0]    hi_q;
  logic signed [aos_pkg::MUL_A_W:0]    hi_sum;
  logic [aos_pkg::MUL_B_W-1:0]         lo_q;

  // one multiplier bit per cycle, partial product shifts right
  assign hi_sum = hi_q + (lo_q[0] ? (aos_pkg::MUL_A_W+1)'(a_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == aos_pkg::MUL_C_W'(aos_pkg::MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_sum >>> 1;
      lo_q <= {hi_sum[0], lo_q[aos_pkg::MUL_B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = aos_pkg::MUL_P_W'({hi_q, lo_q});

endmodule

// ===== hdl/aos_cordic.sv =====
`timescale 1ns / 1ps
module aos_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [31:0]                 d_i,
  output logic                               done_o,
  output logic signed [aos_pkg::ANG_W-1:0]   z_o
);

  localparam int XY_W = 36;
  localparam int Z_W  = 33;

  logic                       busy_q;
  logic                       done_q;
  logic [aos_pkg::STEP_W-1:0] i_q;
  logic signed [XY_W-1:0]     x_q;
  logic signed [XY_W-1:0]     y_q;
  logic signed [Z_W-1:0]      z_q;
  logic                       neg_q;
  logic                       zero_q;
  logic signed [XY_W-1:0]     xs;
  logic signed [XY_W-1:0]     ys;
  logic signed [Z_W-1:0]      ang;
  logic signed [Z_W-1:0]      zc;

  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign ang = Z_W'(aos_pkg::TURN_TAB[i_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == aos_pkg::STEP_W'(aos_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= XY_W'(64'd1 << 26);
      y_q    <= d_i[31] ? -XY_W'(d_i) : XY_W'(d_i);
      z_q    <= '0;
      neg_q  <= d_i[31];
      zero_q <= (d_i == '0);
    end else if (busy_q) begin
      if (!y_q[XY_W-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  always_comb begin
    if (zero_q || z_q[Z_W-1]) begin
      zc = '0;
    end else if (z_q > Z_W'(64'd1 << 30)) begin
      zc = Z_W'(64'd1 << 30);
    end else begin
      zc = z_q;
    end
  end

  assign done_o = done_q;
  assign z_o    = neg_q ? -aos_pkg::ANG_W'(zc) : aos_pkg::ANG_W'(zc);

endmodule

// ===== hdl/arctan_overdrive_sample_top.sv =====
`timescale 1ns / 1ps
// Arctangent soft-clip overdrive, one audio sample per transaction. The sample
// is added to its channel's previous sample, driven, clipped by a 16-step
// CORDIC, scaled back, mixed wet/dry, scaled by volume and saturated to Q1.15.
// One transaction is processed at a time: one pass of the shared bit-serial
// multiplier for the drive, one CORDIC pass, then four more multiplier passes
// for the inverse gain, dry, wet and volume scaling, each pass running its
// steps and then signalling done. The result register is then loaded and the
// block returns to idle. The result register lets the next input be taken
// while the previous result waits on the output. A result that is still
// waiting when the next one is ready holds the block until it is taken.
`include "assert_macros.svh"
module arctan_overdrive_sample_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample_in
  input  logic        s_axis_tuser_i,   // [0] channel_index
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] sample_out
  output logic [1:0]  m_axis_tuser_o    // [0] channel_out, [1] clipped
);

  aos_pkg::state_e state_q, state_d;

  logic [14:0] drive_q;
  logic [14:0] inv_q;
  logic [15:0] wet_mix_q;
  logic [14:0] vol_q;

  logic signed [15:0] prev_q [aos_pkg::CHANNELS];
  logic               ch_q;
  logic signed [15:0] x_q;
  logic signed [26:0] wet_q, wet_d;
  logic signed [31:0] t_q, t_d;
  logic        [15:0] res_q, res_d;
  logic               clip_q, clip_d;
  logic               out_valid_q;
  logic        [15:0] out_data_q;
  logic        [1:0]  out_user_q;

  logic                                 in_acc;
  logic                                 hist;
  logic signed [16:0]                   prev_sel;
  logic [15:0]                          m_eff;
  logic [15:0]                          dry;
  logic                                 mul_start;
  logic signed [aos_pkg::MUL_A_W-1:0]   mul_a;
  logic        [aos_pkg::MUL_B_W-1:0]   mul_b;
  logic                                 mul_done;
  logic signed [aos_pkg::MUL_P_W-1:0]   mul_p;
  logic signed [aos_pkg::MUL_P_W-1:0]   p_rnd;
  logic                                 cor_start;
  logic                                 cor_done;
  logic signed [aos_pkg::ANG_W-1:0]     cor_z;
  logic signed [23:0]                   r;
  logic                                 load_out;
  logic                                 mul_phase;

  assign s_axis_tready_o = (state_q == aos_pkg::S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign hist            = (32'(s_axis_tuser_i) < aos_pkg::CHANNELS);
  assign prev_sel        = hist ? 17'(prev_q[s_axis_tuser_i]) : '0;
  assign m_eff           = (wet_mix_q > 16'h8000) ? 16'h8000 : wet_mix_q;
  assign dry             = 16'h8000 - m_eff;
  assign load_out        = (state_q == aos_pkg::S_OUT) && (!out_valid_q || m_axis_tready_i);
  assign mul_phase       = (state_q == aos_pkg::S_MUL_DRIVE) || (state_q == aos_pkg::S_MUL_INV) ||
                           (state_q == aos_pkg::S_MUL_DRY) || (state_q == aos_pkg::S_MUL_WET) ||
                           (state_q == aos_pkg::S_MUL_VOL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q   <= 15'd1024;
      inv_q     <= 15'd8192;
      wet_mix_q <= 16'd16384;
      vol_q     <= 15'd9192;
    end else if (cfg_we_i) begin
      case (aos_pkg::cfg_idx_e'(cfg_addr_i))
        aos_pkg::REG_DRIVE:   drive_q   <= cfg_wdata_i[14:0];
        aos_pkg::REG_INV:     inv_q     <= cfg_wdata_i[14:0];
        aos_pkg::REG_WET_MIX: wet_mix_q <= cfg_wdata_i;
        aos_pkg::REG_VOLUME:  vol_q     <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < aos_pkg::CHANNELS; c++) begin
        prev_q[c] <= '0;
      end
    end else if (in_acc && hist) begin
      prev_q[s_axis_tuser_i] <= s_axis_tdata_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    wet_d     = wet_q;
    t_d       = t_q;
    res_d     = res_q;
    clip_d    = clip_q;
    p_rnd     = '0;
    r         = '0;
    case (state_q)
      aos_pkg::S_IDLE: begin
        if (in_acc) begin
          mul_start = 1'b1;
          mul_a     = aos_pkg::MUL_A_W'(17'(signed'(s_axis_tdata_i)) + prev_sel);
          mul_b     = aos_pkg::MUL_B_W'(drive_q);
          state_d   = aos_pkg::S_MUL_DRIVE;
        end
      end
      aos_pkg::S_MUL_DRIVE: begin
        if (mul_done) begin
          cor_start = 1'b1;
          state_d   = aos_pkg::S_CORDIC;
        end
      end
      aos_pkg::S_CORDIC: begin
        if (cor_done) begin
          mul_start = 1'b1;
          mul_a     = aos_pkg::MUL_A_W'(cor_z);
          mul_b     = aos_pkg::MUL_B_W'(inv_q);
          state_d   = aos_pkg::S_MUL_INV;
        end
      end
      aos_pkg::S_MUL_INV: begin
        if (mul_done) begin
          p_rnd     = mul_p + aos_pkg::MUL_P_W'(64'd1 << 19);
          wet_d     = p_rnd[46:20];
          mul_start = 1'b1;
          mul_a     = aos_pkg::MUL_A_W'(x_q);
          mul_b     = dry;
          state_d   = aos_pkg::S_MUL_DRY;
        end
      end
      aos_pkg::S_MUL_DRY: begin
        if (mul_done) begin
          t_d       = mul_p[31:0];
          mul_start = 1'b1;
          mul_a     = aos_pkg::MUL_A_W'(wet_q);
          mul_b     = m_eff;
          state_d   = aos_pkg::S_MUL_WET;
        end
      end
      aos_pkg::S_MUL_WET: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_p[aos_pkg::MUL_A_W-1:0] + (aos_pkg::MUL_A_W'(t_q) <<< 8);
          mul_b     = aos_pkg::MUL_B_W'(vol_q);
          state_d   = aos_pkg::S_MUL_VOL;
        end
      end
      aos_pkg::S_MUL_VOL: begin
        if (mul_done) begin
          p_rnd = mul_p + aos_pkg::MUL_P_W'(64'd1 << 35);
          r     = p_rnd[59:36];
          if (r > 24'sd32767) begin
            res_d  = 16'h7FFF;
            clip_d = 1'b1;
          end else if (r < -24'sd32768) begin
            res_d  = 16'h8000;
            clip_d = 1'b1;
          end else begin
            res_d  = r[15:0];
            clip_d = 1'b0;
          end
          state_d = aos_pkg::S_OUT;
        end
      end
      aos_pkg::S_OUT: begin
        if (load_out) begin
          state_d = aos_pkg::S_IDLE;
        end
      end
      default: state_d = aos_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aos_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q <= s_axis_tuser_i;
      x_q  <= s_axis_tdata_i;
    end
    wet_q  <= wet_d;
    t_q    <= t_d;
    res_q  <= res_d;
    clip_q <= clip_d;
    if (load_out) begin
      out_data_q <= res_q;
      out_user_q <= {clip_q, ch_q};
    end
  end

  aos_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  aos_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .d_i     (mul_p[31:0]),
    .done_o  (cor_done),
    .z_o     (cor_z)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `AOS_ASSERT_NEXT(a_accept_starts, in_acc, state_q == aos_pkg::S_MUL_DRIVE, "accept did not start")
  `AOS_ASSERT(a_cordic_done_state, !cor_done || state_q == aos_pkg::S_CORDIC, "stray cordic done")
  `AOS_ASSERT(a_mul_done_state, !mul_done || mul_phase, "stray mul done")
  `AOS_ASSERT(a_clip_full_scale, !(m_axis_tvalid_o && m_axis_tuser_o[1]) || m_axis_tdata_o == 16'h7FFF || m_axis_tdata_o == 16'h8000, "clip flag without full scale")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic        chan;
    logic [15:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic        chan;
    logic [15:0] sample;
    logic        clip;
  } drive_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  arctan_overdrive_sample_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sample_item_t  pend_q[$];
  drive_result_t expect_q[$];
  int            n_err = 0;
  bit            no_idle = 0;

  // predictor state
  longint        angle_tab[aos_pkg::CORDIC_STEPS];
  logic signed [15:0] hist[2];
  longint        drive_g = 1024, inv_g = 8192, wet_g = 16384, vol_g = 9192;

  function automatic longint rshift_round(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic void fill_angles();
    longint unsigned acc, t;
    int e;
    for (int i = 0; i < aos_pkg::CORDIC_STEPS; i++) begin
      if (i == 0) begin
        angle_tab[i] = longint'(1) << 29;
      end else begin
        acc = 0;
        for (int k = 0; k < 17; k++) begin
          e = i * (2 * k + 1);
          if (e > 32) break;
          t = (64'd1 << (32 - e)) / longint'(2 * k + 1);
          acc = (k % 2) ? acc - t : acc + t;
        end
        angle_tab[i] = longint'((acc * 64'hA2F9836E + (64'd1 << 33)) >> 34);
      end
    end
  endfunction

  function automatic longint atan_clip(longint d);
    longint xv, yv, zv, xs, ys;
    bit neg;
    neg = d < 0;
    yv = neg ? -d : d;
    xv = longint'(1) << 26;
    zv = 0;
    if (yv == 0) return 0;
    for (int i = 0; i < aos_pkg::CORDIC_STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv += ys; yv -= xs; zv += angle_tab[i];
      end else begin
        xv -= ys; yv += xs; zv -= angle_tab[i];
      end
    end
    if (zv < 0) zv = 0;
    if (zv > (longint'(1) << 30)) zv = longint'(1) << 30;
    return neg ? -zv : zv;
  endfunction

  function automatic drive_result_t overdrive(sample_item_t it);
    drive_result_t r;
    longint xin, wetv, acc, m, o;
    xin = longint'($signed(it.sample));
    wetv = rshift_round(atan_clip((xin + longint'(hist[it.chan])) * drive_g) * inv_g, 20);
    m = (wet_g > 32768) ? 32768 : wet_g;
    acc = (wetv * m + xin * (32768 - m) * 256) * vol_g;
    o = rshift_round(acc, 36);
    r.clip = 1'b0;
    if (o > 32767) begin
      o = 32767; r.clip = 1'b1;
    end else if (o < -32768) begin
      o = -32768; r.clip = 1'b1;
    end
    hist[it.chan] = it.sample;
    r.chan = it.chan;
    r.sample = o[15:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    logic busy;
    sample_item_t it;
    drive_result_t exp_it;
    if (rst_ni) begin
      busy = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        busy = 1'b0;
        it.chan = s_axis_tuser_i;
        it.sample = s_axis_tdata_i;
        exp_it = overdrive(it);
        expect_q = {expect_q, exp_it};
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pend_q.size() > 0) begin
          it = pend_q.pop_front();
          s_axis_tdata_i <= it.sample;
          s_axis_tuser_i <= it.chan;
          busy = 1'b1;
          send_gap = pick_gap();
        end
      end
      s_axis_tvalid_i <= busy;
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk_i) begin
    drive_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.chan = m_axis_tuser_o[0];
        got.clip = m_axis_tuser_o[1];
        got.sample = m_axis_tdata_o;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected transaction ch=%0d out=%0d clip=%0d", $time,
                   got.chan, $signed(got.sample), got.clip);
          n_err++;
        end else begin
          want = expect_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected ch=%0d out=%0d clip=%0d, actual ch=%0d out=%0d clip=%0d",
                     $time, want.chan, $signed(want.sample), want.clip,
                     got.chan, $signed(got.sample), got.clip);
            n_err++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall = pick_gap();
        m_axis_tready_i <= (stall == 0);
      end
    end
  end

  task automatic write_reg(aos_pkg::cfg_idx_e idx, logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      aos_pkg::REG_DRIVE:   drive_g = longint'(v & 16'h7FFF);
      aos_pkg::REG_INV:     inv_g = longint'(v & 16'h7FFF);
      aos_pkg::REG_WET_MIX: wet_g = longint'(v);
      aos_pkg::REG_VOLUME:  vol_g = longint'(v & 16'h7FFF);
      default: ;
    endcase
  endtask

  task automatic set_gains(int dg, int ig, int wm, int vg);
    write_reg(aos_pkg::REG_DRIVE, 16'(dg));
    write_reg(aos_pkg::REG_INV, 16'(ig));
    write_reg(aos_pkg::REG_WET_MIX, 16'(wm));
    write_reg(aos_pkg::REG_VOLUME, 16'(vg));
  endtask

  task automatic push(bit c, logic [15:0] s);
    sample_item_t it;
    it.chan = c;
    it.sample = s;
    pend_q = {pend_q, it};
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || s_axis_tvalid_i || expect_q.size() > 0) @(negedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic push_random(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(3) == 0);
      p = $urandom_range(9);
      if (p < 5) push(1'($urandom_range(1)), 16'($urandom));
      else if (p < 8) push(1'($urandom_range(1)), 16'($signed($urandom_range(0, 2048)) - 1024));
      else push(1'($urandom_range(1)), $urandom_range(1) ? 16'h7FFF : 16'h8000);
    end
  endtask

  task automatic directed_set();
    push(1'b0, 16'h0000); push(1'b1, 16'h0000);
    push(1'b0, 16'h7FFF); push(1'b0, 16'h7FFF);
    push(1'b1, 16'h8000); push(1'b1, 16'h8000);
    push(1'b0, 16'h0001); push(1'b1, 16'hFFFF);
    push(1'b0, 16'h8000); push(1'b1, 16'h7FFF);
    push(1'b0, 16'h5555); push(1'b1, 16'hAAAA);
  endtask

  initial begin
    fill_angles();
    hist[0] = 0;
    hist[1] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed_set();
    drain();
    set_gains(32767, 259, 32768, 32610);
    directed_set();
    drain();
    set_gains(256, 32767, 0, 2056);
    directed_set();
    drain();
    set_gains(4096, 2048, 65535, 8192);
    directed_set();
    drain();
    set_gains(0, 8192, 32768, 8192);
    push(1'b0, 16'h7FFF); push(1'b1, 16'h8000);
    drain();
    set_gains(1024, 0, 20000, 0);
    push(1'b0, 16'h7FFF); push(1'b1, 16'h8000);
    drain();
    write_reg(aos_pkg::REG_VOLUME, 16'd8192);
    push(1'b0, 16'h4000); push(1'b1, 16'hC000);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_gains($urandom_range(256, 32767), $urandom_range(259, 32767),
                ($urandom_range(4) == 0) ? $urandom_range(32769, 65535) : $urandom_range(32768),
                $urandom_range(2056, 32610));
      push_random(62);
      drain();
    end
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/aos_pkg.sv
hdl/aos_mul.sv
hdl/aos_cordic.sv
hdl/arctan_overdrive_sample_top.sv
tb/sv/tb.sv
